@@ design/length_framed_packet_deframer_top_assert.svh @@
// assertion macros used by the deframer checker
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef LENGTH_FRAMED_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_FRAMED_PACKET_DEFRAMER_TOP_ASSERT_SVH

// implication checked in the same cycle
`define LFPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// implication checked in the next cycle
`define LFPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

@@ design/lfpd_pkg.sv @@
// shared types and constants for the length framed packet deframer
// no dependencies
package lfpd_pkg;

   localparam int BYTE_W  = 8;
   localparam int POS_W   = 7;
   localparam int SIZE_W  = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h55;
   localparam logic [SIZE_W-1:0] LIMIT_RESET = 7'd64;

   // frame overhead: start, length and stop bytes
   localparam logic [BYTE_W:0] FRAME_OVERHEAD = 9'd3;
   localparam logic [BYTE_W:0] STOP_OFFSET    = 9'd2;

   localparam logic [POS_W-1:0] POS_IDLE   = 7'd0;
   localparam logic [POS_W-1:0] POS_LENGTH = 7'd1;
   localparam logic [POS_W-1:0] POS_BODY   = 7'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START = 2'd0,
      CSR_STOP  = 2'd1,
      CSR_LIMIT = 2'd2,
      CSR_NONE  = 2'd3
   } csr_idx_type;

   typedef enum logic {
      ST_RECV,
      ST_EMIT
   } state_type;

endpackage

@@ design/lfpd_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module lfpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/length_framed_packet_deframer_top.sv @@
// input: one cycle per byte while receiving; the stop byte write is the last input cycle
// output: each frame byte is read from the frame ram, then loaded into the output register; reads
// and loads alternate, and a read waits until the output register is free or is being taken
// input is stalled while a frame is read out; it reopens as the last byte is loaded
// reset (synchronous, active high) returns to waiting for a start byte and
// restores register defaults; the frame ram is not cleared
module length_framed_packet_deframer_top #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lfpd_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lfpd_pkg::BYTE_W-1:0]       rsp_frame_byte,
   output logic [lfpd_pkg::SIZE_W-1:0]       rsp_frame_size,
   output logic                              rsp_is_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lfpd_pkg::BYTE_W-1:0]       csr_wdata
);

   import lfpd_pkg::*;

   localparam int AW = $clog2(FRAME_DEPTH);
   localparam logic [SIZE_W-1:0] DEPTH_LIMIT = SIZE_W'(FRAME_DEPTH);

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic              rd_pend_ff, rd_pend_in;

   logic [BYTE_W-1:0] start_ff, stop_ff;
   logic [SIZE_W-1:0] limit_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [SIZE_W-1:0] rsp_size_ff, rsp_size_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   logic              req_take, rsp_take, out_free;
   logic [SIZE_W-1:0] eff_limit;
   logic [BYTE_W:0]   len_total, stop_pos;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         stop_ff  <= STOP_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_START: start_ff <= csr_wdata;
            CSR_STOP:  stop_ff  <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata[SIZE_W-1:0];
            default:   ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_RECV);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || rsp_take;

   assign eff_limit = (limit_ff > DEPTH_LIMIT) ? DEPTH_LIMIT : limit_ff;
   assign len_total = {1'b0, req_rx_byte} + FRAME_OVERHEAD;
   assign stop_pos  = {1'b0, len_ff} + STOP_OFFSET;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      size_in      = size_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_pend_in   = rd_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_byte_in  = rsp_byte_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff[AW-1:0];
      ram_re       = 1'b0;
      ram_raddr    = rd_cnt_ff[AW-1:0];

      case (state_ff)
         ST_RECV: begin
            if (req_take) begin
               if (pos_ff == POS_IDLE) begin
                  if (req_rx_byte == start_ff) begin
                     ram_we = 1'b1;
                     pos_in = POS_LENGTH;
                  end
               end else if (pos_ff == POS_LENGTH) begin
                  if (len_total > {2'b00, eff_limit}) begin
                     pos_in = POS_IDLE;
                  end else begin
                     ram_we = 1'b1;
                     len_in = req_rx_byte;
                     pos_in = POS_BODY;
                  end
               end else if ({2'b00, pos_ff} == stop_pos) begin
                  pos_in = POS_IDLE;
                  if (req_rx_byte == stop_ff) begin
                     ram_we    = 1'b1;
                     size_in   = pos_ff + 1'b1;
                     len_in    = '0;
                     rd_cnt_in = '0;
                     state_in  = ST_EMIT;
                  end
               end else begin
                  // body byte; the length check keeps it inside the ram
                  ram_we = 1'b1;
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rd_pend_ff) begin
               rd_pend_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ram_rdata;
               rsp_size_in  = size_ff;
               rsp_last_in  = (rd_cnt_ff == size_ff);
               if (rd_cnt_ff == size_ff) begin
                  state_in = ST_RECV;
               end
            end else if (out_free && (rd_cnt_ff != size_ff)) begin
               // output slot is free by the time the read data lands
               ram_re     = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         default: state_in = ST_RECV;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         pos_ff       <= POS_IDLE;
         len_ff       <= '0;
         size_ff      <= '0;
         rd_cnt_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         size_ff      <= size_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_size_ff <= rsp_size_in;
      rsp_last_ff <= rsp_last_in;
   end

   lfpd_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(FRAME_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_rx_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_size = rsp_size_ff;
   assign rsp_is_last    = rsp_last_ff;

endmodule

@@ design/lfpd_checker.sv @@
// port-level checks for the deframer, bound to the top level
// depends on lfpd_pkg and length_framed_packet_deframer_top_assert.svh
`include "length_framed_packet_deframer_top_assert.svh"

module lfpd_checker #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [lfpd_pkg::BYTE_W-1:0]       rsp_frame_byte,
   input  logic [lfpd_pkg::SIZE_W-1:0]       rsp_frame_size,
   input  logic                              rsp_is_last
);

   import lfpd_pkg::*;

   localparam logic [SIZE_W-1:0] DEPTH_LIMIT = SIZE_W'(FRAME_DEPTH);
   localparam logic [SIZE_W-1:0] MIN_SIZE    = SIZE_W'(3);

   // a stalled result keeps its payload
   `LFPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_frame_size) && $stable(rsp_is_last))

   // frame size is at least three bytes and stays inside what the ram can hold
   `LFPD_ASSERT_NOW(a_size_range, clock, reset, rsp_valid, rsp_frame_size >= MIN_SIZE && rsp_frame_size <= DEPTH_LIMIT)

   // input stays closed while a frame is still being read out
   `LFPD_ASSERT_NOW(a_stall_in_frame, clock, reset, rsp_valid && !rsp_is_last, req_stall)

   // within a frame the input stays closed and the size does not change from one transfer to the next
   `LFPD_ASSERT_NEXT(a_size_steady, clock, reset, rsp_valid && !rsp_stall && !rsp_is_last, req_stall && (!rsp_valid || $stable(rsp_frame_size)))

endmodule

bind length_framed_packet_deframer_top lfpd_checker #(
   .FRAME_DEPTH(FRAME_DEPTH)
) u_lfpd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_frame_byte (rsp_frame_byte),
   .rsp_frame_size (rsp_frame_size),
   .rsp_is_last    (rsp_is_last)
);

@@ test/length_framed_packet_deframer_top_tb.sv @@
// self-checking testbench for length_framed_packet_deframer_top
// depends on lfpd_pkg and the deframer rtl; keeps its own deframer state to predict frames
module length_framed_packet_deframer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfpd_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int FRAME_DEPTH   = 64;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [SIZE_W-1:0] frame_size;
      logic              is_last;
   } frame_result_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [BYTE_W-1:0]    rsp_frame_byte;
   logic [SIZE_W-1:0]    rsp_frame_size;
   logic                 rsp_is_last;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [BYTE_W-1:0]    csr_wdata   = '0;

   // register copies and receive state of the predictor
   logic [BYTE_W-1:0] cfg_start = START_RESET;
   logic [BYTE_W-1:0] cfg_stop  = STOP_RESET;
   logic [SIZE_W-1:0] cfg_limit = LIMIT_RESET;
   logic [POS_W-1:0]  fill_pos  = POS_IDLE;
   logic [BYTE_W-1:0] body_len  = '0;
   logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];

   frame_result_type pending_bytes[$];
   int unsigned   mismatches    = 0;
   int unsigned   framed_bytes  = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   length_framed_packet_deframer_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_size (rsp_frame_size),
      .rsp_is_last    (rsp_is_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // compare every result transfer with the oldest predicted frame byte
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected frame byte %0h", rsp_frame_byte);
            mismatches++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte expected %0h actual %0h", want.frame_byte, rsp_frame_byte);
               mismatches++;
            end
            if (rsp_frame_size !== want.frame_size) begin
               $error("frame_size expected %0d actual %0d", want.frame_size, rsp_frame_size);
               mismatches++;
            end
            if (rsp_is_last !== want.is_last) begin
               $error("is_last expected %0b actual %0b", want.is_last, rsp_is_last);
               mismatches++;
            end
         end
      end
   end

   // the store bounds the usable frame size whatever the register says
   function automatic int unsigned frame_cap();
      return (cfg_limit > FRAME_DEPTH) ? FRAME_DEPTH : cfg_limit;
   endfunction

   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      int unsigned      stop_at;
      frame_result_type r;
      stop_at = body_len + 2;
      if (fill_pos == POS_IDLE) begin
         if (b == cfg_start) begin
            frame_mem[0] = b;
            fill_pos     = POS_LENGTH;
         end
      end else if (fill_pos == POS_LENGTH) begin
         if (int'(b) + 3 > frame_cap()) begin
            fill_pos = POS_IDLE;
         end else begin
            body_len     = b;
            frame_mem[1] = b;
            fill_pos     = POS_BODY;
         end
      end else if (fill_pos == stop_at) begin
         fill_pos = POS_IDLE;
         if (b == cfg_stop) begin
            frame_mem[stop_at] = b;
            for (int unsigned k = 0; k <= stop_at; k++) begin
               r.frame_byte = frame_mem[k];
               r.frame_size = SIZE_W'(stop_at + 1);
               r.is_last    = (k == stop_at);
               pending_bytes.push_back(r);
            end
            body_len = '0;
         end
      end else begin
         frame_mem[fill_pos] = b;
         fill_pos            = fill_pos + 1'b1;
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      // bytes dropped while hunting for a start byte do not count
      if (fill_pos != POS_IDLE || b == cfg_start) framed_bytes++;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(b);
   endtask

   task automatic send_frame(input int unsigned body_n, input logic [BYTE_W-1:0] closing);
      send_byte(cfg_start);
      send_byte(BYTE_W'(body_n));
      repeat (body_n) send_byte(BYTE_W'($urandom));
      send_byte(closing);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [BYTE_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START: cfg_start = value;
         CSR_STOP:  cfg_stop  = value;
         CSR_LIMIT: cfg_limit = value[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic test_basic_frames();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(START_RESET);                  // zero-length body
      send_byte(8'h00);
      send_byte(STOP_RESET);
      send_byte(START_RESET);                  // start and stop values as body data
      send_byte(8'h02);
      send_byte(START_RESET);
      send_byte(STOP_RESET);
      send_byte(STOP_RESET);
      send_byte(START_RESET);                  // length too big, length byte is not a new start
      send_byte(START_RESET);
      send_byte(8'h00);
      send_byte(STOP_RESET);
      send_byte(START_RESET);                  // bad stop equal to start is not a new start
      send_byte(8'h01);
      send_byte(8'h11);
      send_byte(START_RESET);
      send_byte(8'h00);
      send_byte(STOP_RESET);
      send_frame(61, STOP_RESET);              // largest frame that fits
      send_byte(START_RESET);
      send_byte(8'd62);
   endtask

   task automatic test_frame_limits();
      write_reg(CSR_LIMIT, 8'hFF);             // above the store size
      send_frame(61, cfg_stop);
      send_byte(cfg_start);
      send_byte(8'd62);
      write_reg(CSR_LIMIT, 8'd3);
      send_frame(0, cfg_stop);
      send_byte(cfg_start);
      send_byte(8'd1);
      write_reg(CSR_LIMIT, 8'd0);              // nothing can pass
      send_frame(0, cfg_stop);
      write_reg(CSR_LIMIT, 8'd2);
      send_frame(0, cfg_stop);
      write_reg(CSR_LIMIT, 8'd64);
   endtask

   task automatic test_writes_mid_frame();
      send_byte(cfg_start);
      write_reg(CSR_LIMIT, 8'd4);              // applies to the length that follows
      send_byte(8'd2);
      write_reg(CSR_LIMIT, 8'd64);
      send_byte(cfg_start);
      send_byte(8'd2);
      send_byte(8'h11);
      write_reg(CSR_STOP, 8'h3C);              // checked when the stop position comes
      send_byte(8'h22);
      send_byte(8'h3C);
      write_reg(CSR_START, 8'h00);
      write_reg(CSR_STOP, 8'hFF);
      write_reg(CSR_NONE, 8'hFF);
      send_frame(1, cfg_stop);
      send_frame(0, 8'hFE);
   endtask

   task automatic send_random_traffic();
      int unsigned cap;
      int unsigned roll;
      int unsigned body_n;
      cap  = frame_cap();
      roll = $urandom_range(99);
      if (cap < 3 || roll < 8) begin
         send_byte(cfg_start);
         send_byte(BYTE_W'($urandom_range((cap >= 2) ? cap - 2 : 0, 255)));
      end else if (roll < 18) begin
         repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
      end else if (roll < 26 && cap > 3) begin
         // frame cut short, the next bytes run into it
         body_n = $urandom_range(1, (cap - 3 < 8) ? cap - 3 : 8);
         send_byte(cfg_start);
         send_byte(BYTE_W'(body_n));
         repeat ($urandom_range(0, body_n - 1)) send_byte(BYTE_W'($urandom));
      end else begin
         if (roll < 92) body_n = $urandom_range(0, (cap - 3 < 8) ? cap - 3 : 8);
         else           body_n = $urandom_range(0, cap - 3);
         if (roll < 84) send_frame(body_n, cfg_stop);
         else           send_frame(body_n, cfg_stop ^ BYTE_W'($urandom_range(1, 255)));
      end
   endtask

   task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [BYTE_W-1:0] start_val,
                                   input logic [BYTE_W-1:0] stop_val,
                                   input logic [BYTE_W-1:0] limit_val);
      int unsigned goal;
      write_reg(CSR_START, start_val);
      write_reg(CSR_STOP, stop_val);
      write_reg(CSR_LIMIT, limit_val);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      goal = framed_bytes + 30;
      while (framed_bytes < goal) send_random_traffic();
      wait_idle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, BYTE_W'($urandom), BYTE_W'($urandom), 8'd64);
      run_random_phase(48, 0, BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom_range(3, 20)));
      run_random_phase(0, 48, BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom_range(65, 255)));
      run_random_phase(18, 18, 8'hFF, 8'h00, BYTE_W'($urandom_range(3, 64)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_frames();
      test_frame_limits();
      test_writes_mid_frame();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0) begin
         $display("length_framed_packet_deframer_top regression: pass");
      end else begin
         $display("length_framed_packet_deframer_top regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("length_framed_packet_deframer_top regression: fail");
      $finish;
   end

endmodule
